### src/led_matrix_frame_command_sequencer_core_macros.svh
// assertion macros for the led matrix frame command sequencer
`ifndef LED_MATRIX_FRAME_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define LED_MATRIX_FRAME_COMMAND_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LMFCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LMFCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LMFCS_ASSERT_SAME(lbl, ante, cons)
`define LMFCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/lmfcs_pkg.sv
// shared types and constants of the led matrix frame command sequencer
package lmfcs_pkg;

    localparam int STEP_W      = 3;
    localparam int SETUP_WORDS = 4;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_SETUP        = 4'd0,
        OP_SET_ROW      = 4'd1,
        OP_SET_COL      = 4'd2,
        OP_CLEAR        = 4'd3,
        OP_RENDER       = 4'd4,
        OP_CLEAR_RENDER = 4'd5,
        OP_POWER        = 4'd6,
        OP_BRIGHT       = 4'd7,
        OP_NODECODE     = 4'd8,
        OP_ROWS         = 4'd9
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    localparam logic [7:0] ADDR_ROW0   = 8'h01;
    localparam logic [7:0] ADDR_POWER  = 8'h0C;
    localparam logic [7:0] ADDR_DECODE = 8'h09;
    localparam logic [7:0] ADDR_BRIGHT = 8'h0A;
    localparam logic [7:0] ADDR_SCAN   = 8'h0B;

    localparam logic [7:0] POWER_ON       = 8'h01;
    localparam logic [7:0] BRIGHT_SETUP   = 8'h02;
    localparam logic [7:0] BRIGHT_DEFAULT = 8'h08;
    localparam logic [7:0] DECODE_OFF     = 8'h00;

    localparam logic [7:0] BRIGHT_LEVELS [4] = '{8'h02, 8'h05, 8'h08, 8'h0B};

    typedef struct packed {
        logic  take;
        logic  load;
        step_t step;
        logic  last;
    } dp_cmd_t;

    typedef struct packed {
        logic is_set_up;
        logic slot_free;
    } dp_stat_t;

    function automatic logic [7:0] bright_level(input logic [7:0] lvl);
        logic [7:0] res;
        if (lvl < 8'd4)
        begin
            res = BRIGHT_LEVELS[lvl[1:0]];
        end
        else
        begin
            res = BRIGHT_DEFAULT;
        end
        return res;
    endfunction

endpackage

### src/lmfcs_intf.sv
// command and display word channel interfaces
interface lmfcs_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] op;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output op, output index, output data, input ready);
    modport sink (input valid, input op, input index, input data, output ready);
endinterface

interface lmfcs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        last;

    modport source (output valid, output word, output last, input ready);
    modport sink (input valid, input word, input last, output ready);
endinterface

### src/lmfcs_ctrl.sv
// controller state machine sequencing the command words of one transaction
`include "led_matrix_frame_command_sequencer_core_macros.svh"

module lmfcs_ctrl #(
    parameter int ROW_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [3:0]           in_op,
    output logic                 in_ready,
    input  lmfcs_pkg::dp_stat_t  stat,
    output lmfcs_pkg::dp_cmd_t   cmd
);

    lmfcs_pkg::ctrl_state_t state_reg, state_next;
    lmfcs_pkg::step_t       step_reg, step_next;
    lmfcs_pkg::step_t       last_idx_reg, last_idx_next;

    logic             has_words;
    lmfcs_pkg::step_t words_last;

    // word count of the incoming transaction
    always_comb
    begin
        has_words  = 1'b0;
        words_last = '0;
        case (lmfcs_pkg::op_t'(in_op))
            lmfcs_pkg::OP_SETUP:
            begin
                has_words  = 1'b1;
                words_last = lmfcs_pkg::step_t'(lmfcs_pkg::SETUP_WORDS - 1);
            end
            lmfcs_pkg::OP_RENDER, lmfcs_pkg::OP_CLEAR_RENDER:
            begin
                has_words  = stat.is_set_up;
                words_last = lmfcs_pkg::step_t'(ROW_COUNT - 1);
            end
            lmfcs_pkg::OP_POWER, lmfcs_pkg::OP_BRIGHT,
            lmfcs_pkg::OP_NODECODE, lmfcs_pkg::OP_ROWS:
            begin
                has_words = stat.is_set_up;
            end
            default:
            begin
                has_words = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        last_idx_next = last_idx_reg;
        case (state_reg)
            lmfcs_pkg::ST_IDLE:
            begin
                if (in_valid && has_words)
                begin
                    state_next    = lmfcs_pkg::ST_EMIT;
                    step_next     = '0;
                    last_idx_next = words_last;
                end
            end
            lmfcs_pkg::ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    if (step_reg == last_idx_reg)
                    begin
                        state_next = lmfcs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + lmfcs_pkg::step_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = lmfcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd.take  = 1'b0;
        cmd.load  = 1'b0;
        cmd.step  = step_reg;
        cmd.last  = (step_reg == last_idx_reg);
        case (state_reg)
            lmfcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            lmfcs_pkg::ST_EMIT:
            begin
                cmd.load = stat.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lmfcs_pkg::ST_IDLE;
            step_reg     <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            last_idx_reg <= last_idx_next;
        end
    end

    `LMFCS_ASSERT_SAME(a_take_load_apart, cmd.take, !cmd.load)
    `LMFCS_ASSERT_SAME(a_load_needs_slot, cmd.load, stat.slot_free)
    `LMFCS_ASSERT_NEXT(a_last_ends, cmd.load && cmd.last, state_reg == lmfcs_pkg::ST_IDLE)
    `LMFCS_ASSERT_SAME(a_step_bound, state_reg == lmfcs_pkg::ST_EMIT, step_reg <= last_idx_reg)

endmodule

### src/lmfcs_dp.sv
// datapath with frame buffer, setup flag, word builder and output register
module lmfcs_dp #(
    parameter int ROW_COUNT = 8,
    parameter int COL_COUNT = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          in_op,
    input  logic [7:0]          in_index,
    input  logic [7:0]          in_data,
    input  lmfcs_pkg::dp_cmd_t  cmd,
    output lmfcs_pkg::dp_stat_t stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_word,
    output logic                out_last
);

    logic [COL_COUNT-1:0] frame_reg [ROW_COUNT];
    logic [COL_COUNT-1:0] frame_next [ROW_COUNT];
    logic                 set_up_reg, set_up_next;
    lmfcs_pkg::op_t       op_reg;
    logic [7:0]           data_reg;
    logic                 out_valid_reg;
    logic [15:0]          word_reg, word_next;
    logic                 last_reg;
    logic [COL_COUNT-1:0] row_sel;
    logic                 slot_free;

    assign slot_free      = !out_valid_reg || out_ready;
    assign stat.slot_free = slot_free;
    assign stat.is_set_up = set_up_reg;

    always_comb
    begin
        frame_next  = frame_reg;
        set_up_next = set_up_reg;
        if (cmd.take)
        begin
            case (lmfcs_pkg::op_t'(in_op))
                lmfcs_pkg::OP_SETUP:
                begin
                    set_up_next = 1'b1;
                end
                lmfcs_pkg::OP_SET_ROW:
                begin
                    for (int r = 0; r < ROW_COUNT; r++)
                    begin
                        if (in_index == 8'(r))
                        begin
                            frame_next[r] = in_data[COL_COUNT-1:0];
                        end
                    end
                end
                lmfcs_pkg::OP_SET_COL:
                begin
                    for (int r = 0; r < ROW_COUNT; r++)
                    begin
                        for (int c = 0; c < COL_COUNT; c++)
                        begin
                            if (in_index == 8'(COL_COUNT - 1 - c))
                            begin
                                frame_next[r][c] = in_data[ROW_COUNT-1-r];
                            end
                        end
                    end
                end
                lmfcs_pkg::OP_CLEAR, lmfcs_pkg::OP_CLEAR_RENDER:
                begin
                    for (int r = 0; r < ROW_COUNT; r++)
                    begin
                        frame_next[r] = '0;
                    end
                end
                default:
                begin
                    set_up_next = set_up_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        row_sel = '0;
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (cmd.step == lmfcs_pkg::step_t'(r))
            begin
                row_sel = frame_reg[r];
            end
        end
    end

    always_comb
    begin
        word_next = '0;
        case (op_reg)
            lmfcs_pkg::OP_SETUP:
            begin
                case (cmd.step)
                    3'd0:    word_next = {lmfcs_pkg::ADDR_POWER, lmfcs_pkg::POWER_ON};
                    3'd1:    word_next = {lmfcs_pkg::ADDR_BRIGHT, lmfcs_pkg::BRIGHT_SETUP};
                    3'd2:    word_next = {lmfcs_pkg::ADDR_DECODE, lmfcs_pkg::DECODE_OFF};
                    default: word_next = {lmfcs_pkg::ADDR_SCAN, 8'(ROW_COUNT - 1)};
                endcase
            end
            lmfcs_pkg::OP_RENDER, lmfcs_pkg::OP_CLEAR_RENDER:
            begin
                word_next = {lmfcs_pkg::ADDR_ROW0 + 8'(cmd.step), 8'(row_sel)};
            end
            lmfcs_pkg::OP_POWER:
            begin
                word_next = {lmfcs_pkg::ADDR_POWER, data_reg};
            end
            lmfcs_pkg::OP_BRIGHT:
            begin
                word_next = {lmfcs_pkg::ADDR_BRIGHT, lmfcs_pkg::bright_level(data_reg)};
            end
            lmfcs_pkg::OP_NODECODE:
            begin
                word_next = {lmfcs_pkg::ADDR_DECODE, lmfcs_pkg::DECODE_OFF};
            end
            lmfcs_pkg::OP_ROWS:
            begin
                word_next = {lmfcs_pkg::ADDR_SCAN,
                             (data_reg >= 8'(ROW_COUNT)) ? 8'(ROW_COUNT - 1) : data_reg};
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                frame_reg[r] <= '0;
            end
            set_up_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg  <= frame_next;
            set_up_reg <= set_up_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // transaction payload and output word
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg   <= lmfcs_pkg::op_t'(in_op);
            data_reg <= in_data;
        end
        if (cmd.load)
        begin
            word_reg <= word_next;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = word_reg;
    assign out_last  = last_reg;

endmodule

### src/led_matrix_frame_command_sequencer_core.sv
// top level of the led matrix frame command sequencer
//
// channel   dir  payload                      handshake
// in_ch     in   op[3:0] index[7:0] data[7:0] valid/ready
// out_ch    out  word[15:0] last              valid/ready
//
// a command is taken while idle; setup then emits 4 words and, once set
// up, render and clear_render ROW_COUNT words, single-word commands 1 word,
// one per cycle unless the output stalls; no new command is taken until
// the last word is loaded; a stalled output holds the word register and
// pauses the sequence; reset clears the frame buffer and the setup flag
module led_matrix_frame_command_sequencer_core #(
    parameter int ROW_COUNT = 8,
    parameter int COL_COUNT = 8
) (
    input logic         clk,
    input logic         rst_n,
    lmfcs_in_if.sink    in_ch,
    lmfcs_out_if.source out_ch
);

    lmfcs_pkg::dp_cmd_t  cmd;
    lmfcs_pkg::dp_stat_t stat;

    lmfcs_ctrl #(
        .ROW_COUNT (ROW_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lmfcs_dp #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (in_ch.op),
        .in_index  (in_ch.index),
        .in_data   (in_ch.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_word  (out_ch.word),
        .out_last  (out_ch.last)
    );

endmodule

### bench/lmfcs_display_word_checker.sv
// checker that predicts and compares the display words of the led matrix sequencer
`timescale 1ns / 100ps

module lmfcs_display_word_checker #(
    parameter int ROW_COUNT = 8,
    parameter int COL_COUNT = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    lmfcs_in_if   in_ch,
    lmfcs_out_if  out_ch,
    output int    fail_count,
    output int    words_pending
);

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } display_word_t;

    display_word_t expected_words [$];
    logic [7:0]    frame_rows [ROW_COUNT];
    logic          set_up;

    function automatic logic [7:0] level_for(input logic [7:0] lvl);
        logic [7:0] res;
        case (lvl)
            8'd0:    res = 8'h02;
            8'd1:    res = 8'h05;
            8'd2:    res = 8'h08;
            8'd3:    res = 8'h0B;
            default: res = lmfcs_pkg::BRIGHT_DEFAULT;
        endcase
        return res;
    endfunction

    task automatic queue_word(input logic [7:0] addr, input logic [7:0] val);
        display_word_t w;
        if (set_up)
        begin
            w.word = {addr, val};
            w.last = 1'b0;
            expected_words.push_back(w);
        end
    endtask

    task automatic queue_frame();
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            queue_word(lmfcs_pkg::ADDR_ROW0 + 8'(r), frame_rows[r]);
        end
    endtask

    task automatic clear_frame();
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            frame_rows[r] = '0;
        end
    endtask

    task automatic predict_command(input logic [3:0] op, input logic [7:0] idx,
                                   input logic [7:0] dat);
        int         before_count;
        logic [7:0] col_mask;
        before_count = expected_words.size();
        col_mask = 8'((1 << COL_COUNT) - 1);
        case (lmfcs_pkg::op_t'(op))
            lmfcs_pkg::OP_SETUP:
            begin
                set_up = 1'b1;
                queue_word(lmfcs_pkg::ADDR_POWER, lmfcs_pkg::POWER_ON);
                queue_word(lmfcs_pkg::ADDR_BRIGHT, lmfcs_pkg::BRIGHT_SETUP);
                queue_word(lmfcs_pkg::ADDR_DECODE, lmfcs_pkg::DECODE_OFF);
                queue_word(lmfcs_pkg::ADDR_SCAN, 8'(ROW_COUNT - 1));
            end
            lmfcs_pkg::OP_SET_ROW:
            begin
                if (idx < ROW_COUNT)
                begin
                    frame_rows[idx] = dat & col_mask;
                end
            end
            lmfcs_pkg::OP_SET_COL:
            begin
                if (idx < COL_COUNT)
                begin
                    for (int r = 0; r < ROW_COUNT; r++)
                    begin
                        frame_rows[r][COL_COUNT - 1 - idx] = dat[ROW_COUNT - 1 - r];
                    end
                end
            end
            lmfcs_pkg::OP_CLEAR:
            begin
                clear_frame();
            end
            lmfcs_pkg::OP_RENDER:
            begin
                queue_frame();
            end
            lmfcs_pkg::OP_CLEAR_RENDER:
            begin
                clear_frame();
                queue_frame();
            end
            lmfcs_pkg::OP_POWER:
            begin
                queue_word(lmfcs_pkg::ADDR_POWER, dat);
            end
            lmfcs_pkg::OP_BRIGHT:
            begin
                queue_word(lmfcs_pkg::ADDR_BRIGHT, level_for(dat));
            end
            lmfcs_pkg::OP_NODECODE:
            begin
                queue_word(lmfcs_pkg::ADDR_DECODE, lmfcs_pkg::DECODE_OFF);
            end
            lmfcs_pkg::OP_ROWS:
            begin
                queue_word(lmfcs_pkg::ADDR_SCAN,
                           (dat >= ROW_COUNT) ? 8'(ROW_COUNT - 1) : dat);
            end
            default:
            begin
            end
        endcase
        if (expected_words.size() > before_count)
        begin
            expected_words[expected_words.size() - 1].last = 1'b1;
        end
    endtask

    task automatic note_failure(input string what, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        if (fail_count < 10)
        begin
            $display("%0t: %s: expected %h, got %h", $time, what, exp_v, act_v);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        display_word_t exp_w;
        if (!rst_n)
        begin
            expected_words.delete();
            clear_frame();
            set_up = 1'b0;
            fail_count = 0;
            words_pending <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_command(in_ch.op, in_ch.index, in_ch.data);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    note_failure("unexpected word", 16'h0000, out_ch.word);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_ch.word !== exp_w.word)
                    begin
                        note_failure("word mismatch", exp_w.word, out_ch.word);
                    end
                    if (out_ch.last !== exp_w.last)
                    begin
                        note_failure("last mismatch", 16'(exp_w.last), 16'(out_ch.last));
                    end
                end
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

### bench/led_matrix_frame_command_sequencer_core_test.sv
// stimulus and verdict for the led matrix frame command sequencer
`timescale 1ns / 100ps

module led_matrix_frame_command_sequencer_core_test;

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 44;

    localparam logic [3:0] OP_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   fail_count;
    int   words_pending;
    int   cycle_count;

    lmfcs_in_if  cmd_ch ();
    lmfcs_out_if word_ch ();

    led_matrix_frame_command_sequencer_core #(
        .ROW_COUNT(ROWS),
        .COL_COUNT(COLS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (word_ch)
    );

    lmfcs_display_word_checker #(
        .ROW_COUNT(ROWS),
        .COL_COUNT(COLS)
    ) word_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (cmd_ch),
        .out_ch        (word_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        word_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            word_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_command(input logic [3:0] op, input logic [7:0] idx,
                                input logic [7:0] dat);
        if ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
            begin
                @(posedge clk);
            end
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.op    <= op;
        cmd_ch.index <= idx;
        cmd_ch.data  <= dat;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
    endtask

    task automatic wait_for_words();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_random_phase(input int idle, input int stall, input bit hold_midway);
        logic [3:0] op;
        logic [7:0] idx;
        logic [7:0] dat;
        int         useful;
        int         pick;
        idle_pct  = idle;
        stall_pct = stall;
        useful = 0;
        while (useful < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                op = 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            end
            else if (pick < 8)
            begin
                op = lmfcs_pkg::OP_SETUP;
            end
            else
            begin
                op = 4'($urandom_range(lmfcs_pkg::OP_ROWS, lmfcs_pkg::OP_SET_ROW));
            end
            idx = ($urandom_range(11) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(ROWS - 1));
            dat = 8'($urandom);
            if ((op == lmfcs_pkg::OP_BRIGHT || op == lmfcs_pkg::OP_ROWS)
                && $urandom_range(1) == 0)
            begin
                dat = 8'($urandom_range(ROWS));
            end
            send_command(op, idx, dat);
            if (op <= lmfcs_pkg::OP_ROWS
                && !((op == lmfcs_pkg::OP_SET_ROW || op == lmfcs_pkg::OP_SET_COL)
                     && idx >= ROWS))
            begin
                useful++;
            end
            if (hold_midway && useful == PHASE_ITEMS / 2)
            begin
                hold_midway = 1'b0;
                wait_for_words();
            end
        end
        wait_for_words();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.op    <= lmfcs_pkg::OP_SETUP;
        cmd_ch.index <= 8'h00;
        cmd_ch.data  <= 8'h00;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // commands before setup emit nothing but may change the frame, then setup and every op follow
        send_command(lmfcs_pkg::OP_RENDER, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_POWER, 8'h00, 8'h01);
        send_command(lmfcs_pkg::OP_SET_ROW, 8'h00, 8'hA5);
        send_command(lmfcs_pkg::OP_SET_COL, 8'h03, 8'h3C);
        send_command(lmfcs_pkg::OP_SET_ROW, 8'h08, 8'hFF);
        send_command(OP_UNUSED_FIRST, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_SETUP, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_RENDER, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_SET_COL, 8'h07, 8'hFF);
        send_command(lmfcs_pkg::OP_SET_COL, 8'hFF, 8'h00);
        send_command(lmfcs_pkg::OP_SET_ROW, 8'h07, 8'h81);
        send_command(lmfcs_pkg::OP_RENDER, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_CLEAR, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_RENDER, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_POWER, 8'h00, 8'hFF);
        send_command(lmfcs_pkg::OP_BRIGHT, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_BRIGHT, 8'h00, 8'h01);
        send_command(lmfcs_pkg::OP_BRIGHT, 8'h00, 8'h02);
        send_command(lmfcs_pkg::OP_BRIGHT, 8'h00, 8'h03);
        send_command(lmfcs_pkg::OP_BRIGHT, 8'h00, 8'hFF);
        send_command(lmfcs_pkg::OP_NODECODE, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_ROWS, 8'h00, 8'h00);
        send_command(lmfcs_pkg::OP_ROWS, 8'h00, 8'hFF);
        send_command(lmfcs_pkg::OP_SET_ROW, 8'h04, 8'h5A);
        send_command(lmfcs_pkg::OP_CLEAR_RENDER, 8'h00, 8'h00);
        send_command(OP_UNUSED_LAST, 8'hFF, 8'hFF);
        wait_for_words();

        run_random_phase(0, 0, 1'b0);
        run_random_phase(76, 0, 1'b1);
        run_random_phase(0, 76, 1'b0);
        run_random_phase(28, 28, 1'b0);

        idle_pct  = 0;
        stall_pct = 0;
        repeat (2 * ROWS + 4) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
